// File: hw/rtl/bmpq_pkg.sv
// Shared types and constants for the bounded max priority queue.
`timescale 1ns / 1ps
package bmpq_pkg;

  localparam int DATA_W = 32;
  localparam int OCC_W  = 4;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

// File: hw/rtl/bmpq_if.sv
// Request and response channel interfaces of the priority queue.
`timescale 1ns / 1ps
interface bmpq_in_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic signed [bmpq_pkg::DATA_W-1:0]  push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface bmpq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bmpq_pkg::DATA_W-1:0]  pop_value;
  logic [1:0]                          status;
  logic [bmpq_pkg::OCC_W-1:0]          occupancy;

  modport source (output valid, output pop_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input pop_value, input status, input occupancy,
                  output ready);
endinterface

// File: hw/rtl/bmpq_ctrl.sv
// Controller state machine: sequences capture, execute and response.
`timescale 1ns / 1ps
module bmpq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output bmpq_pkg::cmd_t    cmd
);

  bmpq_pkg::state_t state_r;
  bmpq_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmpq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bmpq_pkg::S_IDLE: begin
        if (in_valid) state_nxt = bmpq_pkg::S_EXEC;
      end
      bmpq_pkg::S_EXEC: begin
        state_nxt = bmpq_pkg::S_RESP;
      end
      bmpq_pkg::S_RESP: begin
        if (out_ready) state_nxt = bmpq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = bmpq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      bmpq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      bmpq_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
      end
      bmpq_pkg::S_RESP: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: hw/rtl/bmpq_dp.sv
// Datapath: sorted shift-register cells, entry count and result registers.
`timescale 1ns / 1ps
module bmpq_dp #(
  parameter int CAPACITY = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bmpq_pkg::cmd_t                     cmd,
  input  logic                               in_func,
  input  logic signed [bmpq_pkg::DATA_W-1:0] in_value,
  output logic signed [bmpq_pkg::DATA_W-1:0] pop_value,
  output logic [1:0]                         status,
  output logic [bmpq_pkg::OCC_W-1:0]         occupancy
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  bmpq_pkg::func_t                    func_r;
  logic signed [bmpq_pkg::DATA_W-1:0] value_r;
  logic signed [bmpq_pkg::DATA_W-1:0] entry_r   [CAPACITY];
  logic signed [bmpq_pkg::DATA_W-1:0] entry_nxt [CAPACITY];
  logic signed [bmpq_pkg::DATA_W-1:0] prev_entry [CAPACITY];
  logic signed [bmpq_pkg::DATA_W-1:0] next_entry [CAPACITY];
  logic [CAPACITY-1:0]                keep;
  logic [CAPACITY-1:0]                prev_keep;
  logic [CNT_W-1:0]                   count_r;
  logic [CNT_W-1:0]                   count_nxt;
  logic [CNT_W+bmpq_pkg::OCC_W-1:0]   occ_ext;
  logic                               full;
  logic                               empty;
  logic                               do_push;
  logic                               do_pop;
  bmpq_pkg::status_t                  status_nxt;
  logic signed [bmpq_pkg::DATA_W-1:0] pop_value_nxt;

  logic signed [bmpq_pkg::DATA_W-1:0] pop_value_r;
  bmpq_pkg::status_t                  status_r;
  logic [bmpq_pkg::OCC_W-1:0]         occupancy_r;

  assign full    = (count_r == CNT_W'(CAPACITY));
  assign empty   = (count_r == '0);
  assign do_push = (func_r == bmpq_pkg::FUNC_PUSH) && !full;
  assign do_pop  = (func_r == bmpq_pkg::FUNC_POP) && !empty;

  // On a push, cells >= the new value keep their entry; the first cell that is not
  // takes the new value, later ones take their left neighbor; a pop shifts left.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      keep[i] = (CNT_W'(i) < count_r) && (entry_r[i] >= value_r);
    end
    prev_entry[0] = value_r;
    prev_keep[0]  = 1'b1;
    for (int i = 1; i < CAPACITY; i++) begin
      prev_entry[i] = entry_r[i-1];
      prev_keep[i]  = keep[i-1];
    end
    for (int i = 0; i < CAPACITY - 1; i++) begin
      next_entry[i] = entry_r[i+1];
    end
    next_entry[CAPACITY-1] = entry_r[CAPACITY-1];

    for (int i = 0; i < CAPACITY; i++) begin
      if (do_pop) begin
        entry_nxt[i] = next_entry[i];
      end else if (keep[i]) begin
        entry_nxt[i] = entry_r[i];
      end else if (prev_keep[i]) begin
        entry_nxt[i] = value_r;
      end else begin
        entry_nxt[i] = prev_entry[i];
      end
    end
  end

  always_comb begin
    count_nxt     = count_r;
    status_nxt    = bmpq_pkg::ST_OK;
    pop_value_nxt = '0;
    priority if (func_r == bmpq_pkg::FUNC_PUSH) begin
      if (full) status_nxt = bmpq_pkg::ST_OVERFLOW;
      else      count_nxt  = count_r + CNT_W'(1);
    end else begin
      if (empty) begin
        status_nxt = bmpq_pkg::ST_UNDERFLOW;
      end else begin
        pop_value_nxt = entry_r[0];
        count_nxt     = count_r - CNT_W'(1);
      end
    end
  end

  // Occupancy shows the count modulo 16.
  assign occ_ext = {{bmpq_pkg::OCC_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= bmpq_pkg::func_t'(in_func);
      value_r <= in_value;
    end
    if (cmd.exec) begin
      pop_value_r <= pop_value_nxt;
      status_r    <= status_nxt;
      occupancy_r <= occ_ext[bmpq_pkg::OCC_W-1:0];
      if (do_push || do_pop) begin
        for (int i = 0; i < CAPACITY; i++) begin
          entry_r[i] <= entry_nxt[i];
        end
      end
    end
  end

  assign pop_value = pop_value_r;
  assign status    = status_r;
  assign occupancy = occupancy_r;

endmodule

// File: hw/rtl/bounded_max_priority_queue_core.sv
// Bounded max priority queue: one push or pop request at a time.
// A request is captured in S_IDLE, executed in S_EXEC and answered from S_RESP,
// where its response holds until taken; only then is a new request accepted.
// Reset (rst_n low, synchronous) empties the queue; stored cells are not cleared.
`timescale 1ns / 1ps
module bounded_max_priority_queue_core #(
  parameter int CAPACITY = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  bmpq_in_if.sink            in_req,
  bmpq_out_if.source         out_rsp
);

  bmpq_pkg::cmd_t cmd;

  bmpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd)
  );

  bmpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_func   (in_req.func),
    .in_value  (in_req.push_value),
    .pop_value (out_rsp.pop_value),
    .status    (out_rsp.status),
    .occupancy (out_rsp.occupancy)
  );

endmodule

// File: hw/rtl/bmpq_checker.sv
// Port-level checker for the priority queue, bound to the top level.
`timescale 1ns / 1ps
module bmpq_checker #(
  parameter int CAPACITY = 8
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic signed [bmpq_pkg::DATA_W-1:0] pop_value,
  input logic [1:0]                         status,
  input logic [bmpq_pkg::OCC_W-1:0]         occupancy
);

  // Reset drops any pending response.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("response valid after reset");

  // One request in flight: no new request while a response is pending.
  assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("request accepted while a response is pending");

  // An accepted request blocks further requests in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (in_valid && in_ready) |=> !in_ready)
    else $error("ready held after request accepted");

  // Underflow leaves the queue empty and returns zero.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && status == bmpq_pkg::ST_UNDERFLOW)
                   |-> (occupancy == '0 && pop_value == '0))
    else $error("bad underflow response");

  // Overflow only when full, and returns zero.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && status == bmpq_pkg::ST_OVERFLOW)
                   |-> (occupancy == bmpq_pkg::OCC_W'(CAPACITY) && pop_value == '0))
    else $error("bad overflow response");

endmodule

bind bounded_max_priority_queue_core bmpq_checker #(
  .CAPACITY (CAPACITY)
) u_bmpq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_rsp.valid),
  .pop_value (out_rsp.pop_value),
  .status    (out_rsp.status),
  .occupancy (out_rsp.occupancy)
);

// File: tb/tb_top.sv
// Testbench for the priority queue core: directed request table, then random requests.
`timescale 1ns / 1ps
module tb_top;

  localparam int CAPACITY    = 8;
  localparam int RANDOM_REQS = 1530;
  localparam int DRILL_ROWS  = 23;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_REPORTS = 10;

  typedef logic signed [bmpq_pkg::DATA_W-1:0] word_t;

  typedef struct {
    word_t                      pop_value;
    bmpq_pkg::status_t          status;
    logic [bmpq_pkg::OCC_W-1:0] occupancy;
  } rsp_t;

  typedef struct {
    bmpq_pkg::func_t func;
    word_t           value;
    bit              pinned;
    rsp_t            rsp;
  } drill_row_t;

  logic clk;
  logic rst_n;

  bmpq_in_if  req_if ();
  bmpq_out_if rsp_if ();

  bounded_max_priority_queue_core #(.CAPACITY(CAPACITY)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_if),
    .out_rsp(rsp_if)
  );

  word_t       held_values[$];
  rsp_t        pending_rsps[$];
  bit          req_pinned;
  rsp_t        req_pinned_rsp;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned stall_left;
  bit          sink_calm;
  bit          source_calm;
  drill_row_t  drill_rows[DRILL_ROWS];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Sorted store, largest first; a new value goes behind every value >= it.
  function automatic rsp_t predict_response(bmpq_pkg::func_t f, word_t v);
    rsp_t r;
    int   slot;
    int   i;
    r.pop_value = '0;
    r.status    = bmpq_pkg::ST_OK;
    if (f == bmpq_pkg::FUNC_PUSH) begin
      if (held_values.size() >= CAPACITY) begin
        r.status = bmpq_pkg::ST_OVERFLOW;
      end else begin
        slot = held_values.size();
        for (i = 0; i < held_values.size(); i++) begin
          if (held_values[i] < v) begin
            slot = i;
            break;
          end
        end
        held_values.insert(slot, v);
      end
    end else if (held_values.size() == 0) begin
      r.status = bmpq_pkg::ST_UNDERFLOW;
    end else begin
      r.pop_value = held_values.pop_front();
    end
    r.occupancy = bmpq_pkg::OCC_W'(held_values.size());
    return r;
  endfunction

  function automatic void check_response();
    rsp_t want;
    if (pending_rsps.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display({"cycle %0d: response with no request pending: ",
                  "pop_value %0d status %0d occupancy %0d"},
                 cycle_count, rsp_if.pop_value, rsp_if.status, rsp_if.occupancy);
      return;
    end
    want = pending_rsps.pop_front();
    if (rsp_if.pop_value !== want.pop_value || rsp_if.status !== want.status ||
        rsp_if.occupancy !== want.occupancy) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display({"cycle %0d: expected pop_value %0d status %0d occupancy %0d, ",
                  "got %0d %0d %0d"},
                 cycle_count, want.pop_value, want.status, want.occupancy,
                 rsp_if.pop_value, rsp_if.status, rsp_if.occupancy);
    end
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap(bit calm);
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic word_t pick_value(int unsigned mode);
    case (mode)
      0: return word_t'(int'($urandom_range(0, 6)) - 3);
      1: begin
        case ($urandom_range(0, 5))
          0: return 32'sh7FFFFFFF;
          1: return 32'sh7FFFFFFE;
          2: return 32'sh80000000;
          3: return 32'sh80000001;
          4: return -32'sd1;
          default: return 32'sd0;
        endcase
      end
      default: return word_t'($urandom());
    endcase
  endfunction

  task automatic send_request(bmpq_pkg::func_t f, word_t v, bit pinned, rsp_t rsp);
    int unsigned gap;
    gap = pick_gap(source_calm);
    if (gap != 0) begin
      req_if.valid      <= 1'b0;
      req_if.func       <= 1'($urandom_range(0, 1));
      req_if.push_value <= $urandom();
      repeat (gap) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.func       <= f;
    req_if.push_value <= v;
    req_pinned        <= pinned;
    req_pinned_rsp    <= rsp;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
  endtask

  // Predict on each accepted request, check each accepted response.
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_if.valid && req_if.ready) begin
        if (req_pinned) begin
          void'(predict_response(bmpq_pkg::func_t'(req_if.func), req_if.push_value));
          pending_rsps.push_back(req_pinned_rsp);
        end else begin
          pending_rsps.push_back(
            predict_response(bmpq_pkg::func_t'(req_if.func), req_if.push_value));
        end
      end
      if (rsp_if.valid && rsp_if.ready) check_response();
    end
  end

  always @(posedge clk) begin : sink_pacing
    int unsigned gap;
    if (cycle_count % 200 == 0) sink_calm <= ($urandom_range(0, 3) == 0);
    if (stall_left != 0) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      gap = pick_gap(sink_calm);
      if (gap == 0) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= 1'b0;
        stall_left   <= gap - 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned     sent;
    int unsigned     burst_len;
    int unsigned     push_pct;
    int unsigned     value_mode;
    int              k;
    bmpq_pkg::func_t f;
    rsp_t            no_rsp;

    rst_n             = 1'b0;
    req_if.valid      = 1'b0;
    req_if.func       = 1'b0;
    req_if.push_value = '0;
    rsp_if.ready      = 1'b0;
    req_pinned        = 1'b0;
    req_pinned_rsp    = '{32'sd0, bmpq_pkg::ST_OK, 4'd0};
    mismatch_count    = 0;
    cycle_count       = 0;
    stall_left        = 0;
    sink_calm         = 1'b0;
    source_calm       = 1'b0;
    no_rsp            = '{32'sd0, bmpq_pkg::ST_OK, 4'd0};

    drill_rows = '{
      '{bmpq_pkg::FUNC_POP,  32'sd0,        1'b1, '{32'sd0,        bmpq_pkg::ST_UNDERFLOW, 4'd0}},
      '{bmpq_pkg::FUNC_PUSH, 32'sh7FFFFFFF, 1'b1, '{32'sd0,        bmpq_pkg::ST_OK,        4'd1}},
      '{bmpq_pkg::FUNC_PUSH, 32'sh80000000, 1'b1, '{32'sd0,        bmpq_pkg::ST_OK,        4'd2}},
      '{bmpq_pkg::FUNC_PUSH, 32'sd0,        1'b0, '{32'sd0,        bmpq_pkg::ST_OK,        4'd0}},
      '{bmpq_pkg::FUNC_PUSH, -32'sd1,       1'b0, '{32'sd0,        bmpq_pkg::ST_OK,        4'd0}},
      '{bmpq_pkg::FUNC_PUSH, 32'sd1,        1'b0, '{32'sd0,        bmpq_pkg::ST_OK,        4'd0}},
      '{bmpq_pkg::FUNC_PUSH, 32'sh7FFFFFFF, 1'b0, '{32'sd0,        bmpq_pkg::ST_OK,        4'd0}},
      '{bmpq_pkg::FUNC_PUSH, 32'sh80000000, 1'b0, '{32'sd0,        bmpq_pkg::ST_OK,        4'd0}},
      '{bmpq_pkg::FUNC_PUSH, 32'sh55555555, 1'b1, '{32'sd0,        bmpq_pkg::ST_OK,        4'd8}},
      '{bmpq_pkg::FUNC_PUSH, 32'shAAAAAAAA, 1'b1, '{32'sd0,        bmpq_pkg::ST_OVERFLOW,  4'd8}},
      '{bmpq_pkg::FUNC_POP,  32'shAAAAAAAA, 1'b1, '{32'sh7FFFFFFF, bmpq_pkg::ST_OK,        4'd7}},
      '{bmpq_pkg::FUNC_POP,  32'sd0,        1'b1, '{32'sh7FFFFFFF, bmpq_pkg::ST_OK,        4'd6}},
      '{bmpq_pkg::FUNC_POP,  -32'sd1,       1'b0, '{32'sd0,        bmpq_pkg::ST_OK,        4'd0}},
      '{bmpq_pkg::FUNC_POP,  32'sd0,        1'b0, '{32'sd0,        bmpq_pkg::ST_OK,        4'd0}},
      '{bmpq_pkg::FUNC_POP,  32'sd0,        1'b0, '{32'sd0,        bmpq_pkg::ST_OK,        4'd0}},
      '{bmpq_pkg::FUNC_POP,  32'sd0,        1'b0, '{32'sd0,        bmpq_pkg::ST_OK,        4'd0}},
      '{bmpq_pkg::FUNC_POP,  32'sd0,        1'b0, '{32'sd0,        bmpq_pkg::ST_OK,        4'd0}},
      '{bmpq_pkg::FUNC_POP,  32'sd0,        1'b1, '{32'sh80000000, bmpq_pkg::ST_OK,        4'd0}},
      '{bmpq_pkg::FUNC_POP,  32'sh55555555, 1'b1, '{32'sd0,        bmpq_pkg::ST_UNDERFLOW, 4'd0}},
      '{bmpq_pkg::FUNC_PUSH, 32'shAAAAAAAA, 1'b0, '{32'sd0,        bmpq_pkg::ST_OK,        4'd0}},
      '{bmpq_pkg::FUNC_PUSH, 32'sh55555555, 1'b0, '{32'sd0,        bmpq_pkg::ST_OK,        4'd0}},
      '{bmpq_pkg::FUNC_POP,  32'sd0,        1'b0, '{32'sd0,        bmpq_pkg::ST_OK,        4'd0}},
      '{bmpq_pkg::FUNC_POP,  32'sd0,        1'b0, '{32'sd0,        bmpq_pkg::ST_OK,        4'd0}}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < DRILL_ROWS; k++)
      send_request(drill_rows[k].func, drill_rows[k].value, drill_rows[k].pinned,
                   drill_rows[k].rsp);

    // Bursts lean toward push or pop so the queue swings between full and empty.
    sent = 0;
    while (sent < RANDOM_REQS) begin
      burst_len  = $urandom_range(10, 60);
      value_mode = $urandom_range(0, 3);
      source_calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0: push_pct = 25;
        1: push_pct = 50;
        default: push_pct = 80;
      endcase
      for (k = 0; k < burst_len && sent < RANDOM_REQS; k++) begin
        f = ($urandom_range(0, 99) < push_pct) ? bmpq_pkg::FUNC_PUSH : bmpq_pkg::FUNC_POP;
        send_request(f, pick_value(value_mode), 1'b0, no_rsp);
        sent++;
      end
    end
    req_if.valid <= 1'b0;

    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_rsps.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
